FILE: hdl/plb_pkg.sv
// plb_pkg: widths, codes and shared types of the price-level book ladder.
// No dependencies; used by every other file of the block.
package plb_pkg;

  localparam int BOOK_DEPTH = 5;

  localparam int PRICE_W  = 32;
  localparam int QTY_W    = 16;
  localparam int FUNC_W   = 4;
  localparam int LVL_W    = 3;
  localparam int STATUS_W = 2;

  // level index inside a ladder, and a width that holds both an index and the depth
  localparam int IDX_W = (BOOK_DEPTH > 1) ? $clog2(BOOK_DEPTH) : 1;
  localparam int CMP_W = ((IDX_W > LVL_W) ? IDX_W : LVL_W) + 1;
  localparam logic [CMP_W-1:0] DEPTH_C = CMP_W'(BOOK_DEPTH);

  typedef enum logic [FUNC_W-1:0] {
    FN_INSERT  = 4'd0,
    FN_UPDATE  = 4'd1,
    FN_DELETE  = 4'd2,
    FN_DTHRU   = 4'd3,
    FN_DFROM   = 4'd4,
    FN_OVERLAY = 4'd5,
    FN_READ    = 4'd6,
    FN_CLEAR   = 4'd7,
    FN_TRADE   = 4'd8
  } func_t;

  typedef enum logic [STATUS_W-1:0] {
    STS_DONE  = 2'd0,
    STS_MISS  = 2'd1,
    STS_DROP  = 2'd2,
    STS_RANGE = 2'd3
  } status_t;

  // what every cell of one ladder does in a cycle
  typedef enum logic [3:0] {
    C_NOP,
    C_INSERT,
    C_UPDATE,
    C_DELETE,
    C_SHIFT,
    C_TRIM,
    C_OVERLAY,
    C_READ,
    C_CLEAR
  } cell_op_t;

  typedef struct packed {
    cell_op_t               op;
    logic [PRICE_W-1:0]     price;
    logic [QTY_W-1:0]       qty;
    logic [LVL_W-1:0]       lvl;
  } cell_cmd_t;

  // level picked out by a cell (search stop or indexed level), zero elsewhere
  typedef struct packed {
    logic [PRICE_W-1:0] price;
    logic [QTY_W-1:0]   qty;
  } tap_t;

  typedef enum logic {
    FSM_IDLE,
    FSM_SHIFT
  } fsm_t;

endpackage

FILE: hdl/plb_if.sv
// plb_if: request and response channels of the price-level book ladder.
// Depends on plb_pkg for field widths.
interface plb_req_if;
  logic                          valid;
  logic                          ready;
  logic [plb_pkg::FUNC_W-1:0]    func;
  logic                          side;
  logic [plb_pkg::PRICE_W-1:0]   price;
  logic [plb_pkg::QTY_W-1:0]     quantity;
  logic [plb_pkg::LVL_W-1:0]     level;

  modport source (output valid, func, side, price, quantity, level, input ready);
  modport sink   (input valid, func, side, price, quantity, level, output ready);
endinterface

interface plb_rsp_if;
  logic                          valid;
  logic                          ready;
  logic [plb_pkg::STATUS_W-1:0]  status;
  logic [plb_pkg::PRICE_W-1:0]   level_price;
  logic [plb_pkg::QTY_W-1:0]     level_qty;
  logic [plb_pkg::PRICE_W-1:0]   best_bid_price;
  logic [plb_pkg::QTY_W-1:0]     best_bid_qty;
  logic [plb_pkg::PRICE_W-1:0]   best_ask_price;
  logic [plb_pkg::QTY_W-1:0]     best_ask_qty;
  logic [plb_pkg::PRICE_W-1:0]   last_price_out;
  logic                          top_sane;
  logic                          bids_ordered;
  logic                          asks_ordered;

  modport source (output valid, status, level_price, level_qty, best_bid_price, best_bid_qty,
                  best_ask_price, best_ask_qty, last_price_out, top_sane, bids_ordered,
                  asks_ordered, input ready);
  modport sink   (input valid, status, level_price, level_qty, best_bid_price, best_bid_qty,
                  best_ask_price, best_ask_qty, last_price_out, top_sane, bids_ordered,
                  asks_ordered, output ready);
endinterface

FILE: hdl/plb_cell.sv
// plb_cell: one price level of a ladder, with its search compare and its
// moves to and from the neighbor levels. Depends on plb_pkg.
module plb_cell (
  input  logic                        clk,
  input  logic                        rst,
  input  plb_pkg::cell_cmd_t          cmd,
  input  logic                        is_ask,
  input  logic [plb_pkg::IDX_W-1:0]   idx,
  input  logic [plb_pkg::PRICE_W-1:0] up_p,
  input  logic [plb_pkg::QTY_W-1:0]   up_q,
  input  logic [plb_pkg::PRICE_W-1:0] dn_p,
  input  logic [plb_pkg::QTY_W-1:0]   dn_q,
  input  logic                        found_in,
  input  logic                        hit_in,
  output logic                        found_out,
  output logic                        hit_out,
  output logic [plb_pkg::PRICE_W-1:0] p,
  output logic [plb_pkg::QTY_W-1:0]   q,
  output plb_pkg::tap_t               tap,
  output logic                        ordered
);
  import plb_pkg::*;

  logic [PRICE_W-1:0] p_next;
  logic [QTY_W-1:0]   q_next;
  logic               eq;
  logic               stop;
  logic               at_pos;
  logic               at_lvl;
  logic               sel;
  logic [CMP_W-1:0]   idx_c;
  logic [CMP_W-1:0]   lvl_c;

  assign idx_c = CMP_W'(idx);
  assign lvl_c = CMP_W'(cmd.lvl);

  // search stops at an empty level, a match, or where the price belongs
  assign eq     = (cmd.price == p);
  assign stop   = (p == '0) || eq || (is_ask ? (cmd.price < p) : (cmd.price > p));
  assign at_pos = !found_in && stop;
  assign at_lvl = (idx_c == lvl_c);

  assign found_out = found_in || stop;
  assign hit_out   = found_in ? hit_in : (stop && eq);

  assign sel = (cmd.op == C_OVERLAY || cmd.op == C_READ) ? at_lvl : at_pos;
  assign tap.price = sel ? p : '0;
  assign tap.qty   = sel ? q : '0;

  // nonzero level must sit strictly past a nonzero level above it
  assign ordered = (idx == '0) || (p == '0) ||
                   ((up_p != '0) && (is_ask ? (p > up_p) : (p < up_p)));

  always_comb begin
    p_next = p;
    q_next = q;
    case (cmd.op)
      C_INSERT: begin
        if (at_pos && !eq) begin
          p_next = cmd.price;
          q_next = cmd.qty;
        end else if (found_in && !hit_in) begin
          p_next = up_p;
          q_next = up_q;
        end
      end
      C_UPDATE: begin
        if (at_pos && eq) q_next = cmd.qty;
      end
      C_DELETE: begin
        if ((at_pos && eq) || (found_in && hit_in)) begin
          p_next = dn_p;
          q_next = dn_q;
        end
      end
      C_SHIFT: begin
        p_next = dn_p;
        q_next = dn_q;
      end
      C_TRIM: begin
        if ((lvl_c != '0) && (idx_c + CMP_W'(1) >= lvl_c)) begin
          p_next = '0;
          q_next = '0;
        end
      end
      C_OVERLAY: begin
        if (at_lvl) begin
          p_next = cmd.price;
          if (cmd.qty != '0) q_next = cmd.qty;
        end
      end
      C_CLEAR: begin
        p_next = '0;
        q_next = '0;
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      p <= '0;
      q <= '0;
    end else begin
      p <= p_next;
      q <= q_next;
    end
  end

endmodule

FILE: hdl/plb_ladder.sv
// plb_ladder: one side of the book as a row of plb_cell, level 0 first.
// Depends on plb_pkg and plb_cell.
module plb_ladder (
  input  logic                        clk,
  input  logic                        rst,
  input  plb_pkg::cell_cmd_t          cmd,
  input  logic                        is_ask,
  output logic [plb_pkg::PRICE_W-1:0] top_p,
  output logic [plb_pkg::QTY_W-1:0]   top_q,
  output logic                        found,
  output logic                        hit,
  output plb_pkg::tap_t               tap,
  output logic                        ordered
);
  import plb_pkg::*;

  logic [PRICE_W-1:0] p      [BOOK_DEPTH];
  logic [QTY_W-1:0]   q      [BOOK_DEPTH];
  logic [PRICE_W-1:0] up_p   [BOOK_DEPTH];
  logic [QTY_W-1:0]   up_q   [BOOK_DEPTH];
  logic [PRICE_W-1:0] dn_p   [BOOK_DEPTH];
  logic [QTY_W-1:0]   dn_q   [BOOK_DEPTH];
  tap_t               taps   [BOOK_DEPTH];
  logic [BOOK_DEPTH-1:0] ok;
  logic [BOOK_DEPTH:0]   found_c;
  logic [BOOK_DEPTH:0]   hit_c;

  assign found_c[0] = 1'b0;
  assign hit_c[0]   = 1'b0;

  for (genvar i = 0; i < BOOK_DEPTH; i++) begin : g_cell
    if (i == 0) begin : g_first
      assign up_p[i] = '0;
      assign up_q[i] = '0;
    end else begin : g_mid
      assign up_p[i] = p[i-1];
      assign up_q[i] = q[i-1];
    end
    if (i == BOOK_DEPTH - 1) begin : g_last
      assign dn_p[i] = '0;
      assign dn_q[i] = '0;
    end else begin : g_more
      assign dn_p[i] = p[i+1];
      assign dn_q[i] = q[i+1];
    end

    plb_cell u_cell (
      .clk       (clk),
      .rst       (rst),
      .cmd       (cmd),
      .is_ask    (is_ask),
      .idx       (IDX_W'(i)),
      .up_p      (up_p[i]),
      .up_q      (up_q[i]),
      .dn_p      (dn_p[i]),
      .dn_q      (dn_q[i]),
      .found_in  (found_c[i]),
      .hit_in    (hit_c[i]),
      .found_out (found_c[i+1]),
      .hit_out   (hit_c[i+1]),
      .p         (p[i]),
      .q         (q[i]),
      .tap       (taps[i]),
      .ordered   (ok[i])
    );
  end

  // at most one cell taps out, so an OR collects it
  always_comb begin
    tap = '0;
    for (int i = 0; i < BOOK_DEPTH; i++) begin
      tap = tap | taps[i];
    end
  end

  assign top_p   = p[0];
  assign top_q   = q[0];
  assign found   = found_c[BOOK_DEPTH];
  assign hit     = hit_c[BOOK_DEPTH];
  assign ordered = &ok;

endmodule

FILE: hdl/price_level_book_ladder.sv
// price_level_book_ladder: top level of the fixed-depth price-level book.
// Depends on plb_pkg, plb_if (plb_req_if, plb_rsp_if) and plb_ladder.
//
//  channel | dir | handshake     | word
//  --------+-----+---------------+-------------------------------------------
//  req     | in  | valid / ready | func, side, price, quantity, level
//  rsp     | out | valid / ready | status, touched level, best bid/ask,
//          |     |               | last trade, sanity flags
//
// Flow: one word per cycle for every request but delete_thru while rsp is
// not stalled; delete_thru moves the ladder up one level per cycle through
// the cell chain, min(level, BOOK_DEPTH) levels in all, before its response word.
// The response sits in an output register; a new request is taken in the
// cycle that register is emptied. Best prices and flags are read live from the
// cells (prices and top_sane from level 0), which stay put while a response waits.
// Reset (rst, synchronous) empties both ladders and last trade and drops
// any pending response. A stalled rsp holds the request side off.
module price_level_book_ladder (
  input  logic           clk,
  input  logic           rst,
  plb_req_if.sink        req,
  plb_rsp_if.source      rsp
);
  import plb_pkg::*;

  fsm_t               fsm;
  fsm_t               fsm_next;
  logic [CMP_W-1:0]   shift_left;
  logic [CMP_W-1:0]   shift_left_next;
  logic               shift_side;
  logic               shift_side_next;
  logic               out_valid;
  logic               out_valid_next;
  logic [STATUS_W-1:0] res_status;
  logic [PRICE_W-1:0] res_price;
  logic [QTY_W-1:0]   res_qty;
  logic [PRICE_W-1:0] last_trade;

  logic               accept;
  func_t              fn;
  logic [CMP_W-1:0]   lvl_c;
  logic [CMP_W-1:0]   n_del;
  cell_op_t           req_op;
  logic               op_side;
  cell_cmd_t          bid_cmd;
  cell_cmd_t          ask_cmd;

  logic [PRICE_W-1:0] bid_top_p;
  logic [QTY_W-1:0]   bid_top_q;
  logic               bid_found;
  logic               bid_hit;
  tap_t               bid_tap;
  logic               bid_ok;
  logic [PRICE_W-1:0] ask_top_p;
  logic [QTY_W-1:0]   ask_top_q;
  logic               ask_found;
  logic               ask_hit;
  tap_t               ask_tap;
  logic               ask_ok;

  logic               sel_found;
  logic               sel_hit;
  tap_t               sel_tap;
  logic [STATUS_W-1:0] st_c;
  logic [PRICE_W-1:0] lp_c;
  logic [QTY_W-1:0]   lq_c;

  assign req.ready = (fsm == FSM_IDLE) && (!out_valid || rsp.ready);
  assign accept    = req.valid && req.ready;
  assign fn        = func_t'(req.func);
  assign lvl_c     = CMP_W'(req.level);
  assign n_del     = (lvl_c < DEPTH_C) ? lvl_c : DEPTH_C;

  // per-ladder command: only the named side acts, clear hits both
  always_comb begin
    req_op  = C_NOP;
    op_side = req.side;
    if (fsm == FSM_SHIFT) begin
      req_op  = C_SHIFT;
      op_side = shift_side;
    end else if (accept) begin
      unique case (fn)
        FN_INSERT:  req_op = (req.price != '0) ? C_INSERT : C_NOP;
        FN_UPDATE:  req_op = (req.price != '0) ? C_UPDATE : C_NOP;
        FN_DELETE:  req_op = (req.price != '0) ? C_DELETE : C_NOP;
        FN_DTHRU:   req_op = (n_del != '0) ? C_SHIFT : C_NOP;
        FN_DFROM:   req_op = C_TRIM;
        FN_OVERLAY: req_op = C_OVERLAY;
        FN_READ:    req_op = C_READ;
        FN_CLEAR:   req_op = C_CLEAR;
        default:    req_op = C_NOP;
      endcase
    end
  end

  always_comb begin
    bid_cmd.price = req.price;
    bid_cmd.qty   = req.quantity;
    bid_cmd.lvl   = req.level;
    bid_cmd.op    = (req_op == C_CLEAR || !op_side) ? req_op : C_NOP;
    ask_cmd       = bid_cmd;
    ask_cmd.op    = (req_op == C_CLEAR || op_side) ? req_op : C_NOP;
  end

  plb_ladder u_bids (
    .clk     (clk),
    .rst     (rst),
    .cmd     (bid_cmd),
    .is_ask  (1'b0),
    .top_p   (bid_top_p),
    .top_q   (bid_top_q),
    .found   (bid_found),
    .hit     (bid_hit),
    .tap     (bid_tap),
    .ordered (bid_ok)
  );

  plb_ladder u_asks (
    .clk     (clk),
    .rst     (rst),
    .cmd     (ask_cmd),
    .is_ask  (1'b1),
    .top_p   (ask_top_p),
    .top_q   (ask_top_q),
    .found   (ask_found),
    .hit     (ask_hit),
    .tap     (ask_tap),
    .ordered (ask_ok)
  );

  assign sel_found = req.side ? ask_found : bid_found;
  assign sel_hit   = req.side ? ask_hit   : bid_hit;
  assign sel_tap   = req.side ? ask_tap   : bid_tap;

  // response word from the ladder as it stands before the update
  always_comb begin
    st_c = STS_DONE;
    lp_c = '0;
    lq_c = '0;
    unique case (fn)
      FN_INSERT: begin
        if (req.price == '0) begin
          st_c = STS_MISS;
        end else if (sel_hit) begin
          st_c = STS_MISS;
          lp_c = sel_tap.price;
          lq_c = sel_tap.qty;
        end else if (!sel_found) begin
          st_c = STS_DROP;
        end else begin
          lp_c = req.price;
          lq_c = req.quantity;
        end
      end
      FN_UPDATE: begin
        if (req.price == '0 || !sel_hit) begin
          st_c = STS_MISS;
        end else begin
          lp_c = sel_tap.price;
          lq_c = req.quantity;
        end
      end
      FN_DELETE: begin
        if (req.price == '0 || !sel_hit) begin
          st_c = STS_MISS;
        end else begin
          lp_c = sel_tap.price;
          lq_c = sel_tap.qty;
        end
      end
      FN_DFROM: begin
        if (lvl_c == '0 || lvl_c > DEPTH_C) st_c = STS_RANGE;
      end
      FN_OVERLAY: begin
        if (lvl_c >= DEPTH_C) begin
          st_c = STS_RANGE;
        end else begin
          lp_c = req.price;
          lq_c = (req.quantity != '0) ? req.quantity : sel_tap.qty;
        end
      end
      FN_READ: begin
        if (lvl_c >= DEPTH_C) begin
          st_c = STS_RANGE;
        end else begin
          lp_c = sel_tap.price;
          lq_c = sel_tap.qty;
        end
      end
      default: begin
      end
    endcase
  end

  // sequencer: idle, or walking the delete_thru shift one level per cycle
  always_comb begin
    fsm_next        = fsm;
    shift_left_next = shift_left;
    shift_side_next = shift_side;
    out_valid_next  = out_valid && !rsp.ready;
    unique case (fsm)
      FSM_IDLE: begin
        if (accept) begin
          if (fn == FN_DTHRU && n_del > CMP_W'(1)) begin
            fsm_next        = FSM_SHIFT;
            shift_left_next = n_del - CMP_W'(1);
            shift_side_next = req.side;
            out_valid_next  = 1'b0;
          end else begin
            out_valid_next  = 1'b1;
          end
        end
      end
      FSM_SHIFT: begin
        shift_left_next = shift_left - CMP_W'(1);
        if (shift_left == CMP_W'(1)) begin
          fsm_next       = FSM_IDLE;
          out_valid_next = 1'b1;
        end
      end
      default: fsm_next = FSM_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      fsm        <= FSM_IDLE;
      shift_left <= '0;
      shift_side <= 1'b0;
      out_valid  <= 1'b0;
      last_trade <= '0;
    end else begin
      fsm        <= fsm_next;
      shift_left <= shift_left_next;
      shift_side <= shift_side_next;
      out_valid  <= out_valid_next;
      if (accept && fn == FN_TRADE) last_trade <= req.price;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      res_status <= st_c;
      res_price  <= lp_c;
      res_qty    <= lq_c;
    end
  end

  assign rsp.valid          = out_valid;
  assign rsp.status         = res_status;
  assign rsp.level_price    = res_price;
  assign rsp.level_qty      = res_qty;
  assign rsp.best_bid_price = bid_top_p;
  assign rsp.best_bid_qty   = bid_top_q;
  assign rsp.best_ask_price = ask_top_p;
  assign rsp.best_ask_qty   = ask_top_q;
  assign rsp.last_price_out = last_trade;
  // both tops empty, or a live ask under the bid, is not sane
  assign rsp.top_sane       = !((bid_top_p == '0) && (ask_top_p == '0)) &&
                              !((ask_top_p != '0) && (bid_top_p > ask_top_p));
  assign rsp.bids_ordered   = bid_ok;
  assign rsp.asks_ordered   = ask_ok;

endmodule

FILE: hdl/plb_checker.sv
// plb_checker: port-level assertions for price_level_book_ladder, bound in below.
// Depends on plb_pkg.
module plb_checker (
  input logic                          clk,
  input logic                          rst,
  input logic                          req_valid,
  input logic                          req_ready,
  input logic [plb_pkg::FUNC_W-1:0]    req_func,
  input logic [plb_pkg::PRICE_W-1:0]   req_price,
  input logic [plb_pkg::LVL_W-1:0]     req_level,
  input logic                          rsp_valid,
  input logic                          rsp_ready,
  input logic [plb_pkg::STATUS_W-1:0]  rsp_status,
  input logic [plb_pkg::PRICE_W-1:0]   best_bid_price,
  input logic [plb_pkg::PRICE_W-1:0]   best_ask_price,
  input logic [plb_pkg::PRICE_W-1:0]   last_price_out
);
  import plb_pkg::*;

  logic req_take;
  assign req_take = !rst && req_valid && req_ready;

  a_rsp_hold: assert property (@(posedge clk) disable iff (rst)
    rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_status))
    else $error("response word changed while stalled");

  a_clear: assert property (@(posedge clk) disable iff (rst)
    req_take && req_func == FN_CLEAR |=>
      rsp_valid && best_bid_price == '0 && best_ask_price == '0)
    else $error("clear left a level in the book");

  a_trade: assert property (@(posedge clk) disable iff (rst)
    req_take && req_func == FN_TRADE |=> rsp_valid && last_price_out == $past(req_price))
    else $error("trade price not recorded");

  a_read_range: assert property (@(posedge clk) disable iff (rst)
    req_take && req_func == FN_READ && {1'b0, req_level} >= (LVL_W+1)'(BOOK_DEPTH) |=>
      rsp_valid && rsp_status == STS_RANGE)
    else $error("read past depth not flagged");

endmodule

bind price_level_book_ladder plb_checker u_plb_checker (
  .clk            (clk),
  .rst            (rst),
  .req_valid      (req.valid),
  .req_ready      (req.ready),
  .req_func       (req.func),
  .req_price      (req.price),
  .req_level      (req.level),
  .rsp_valid      (rsp.valid),
  .rsp_ready      (rsp.ready),
  .rsp_status     (rsp.status),
  .best_bid_price (rsp.best_bid_price),
  .best_ask_price (rsp.best_ask_price),
  .last_price_out (rsp.last_price_out)
);
